/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every edge out of reset
`define SSP_ASSERT_NOW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("sprite projection check failed");

// check that a condition in one cycle implies another in the next
`define SSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprite projection sequence check failed");

`endif

/* src/ssp_pkg.sv */
package ssp_pkg;

   localparam int SCREEN_SIZE   = 1024;
   localparam int SCREEN_CENTER = 512;

   localparam int SQ_W      = 34;
   localparam int RT_W      = 17;
   localparam int SQRT_LAT  = RT_W;

   localparam int DIV_NW    = 44;
   localparam int DIV_DW    = 34;
   localparam int DIV_QW    = 16;
   localparam int DIV_LAT   = DIV_QW + 3;

   typedef struct packed {
      logic                 valid;
      logic signed [15:0]   s;
      logic signed [33:0]   tx;
      logic signed [33:0]   ty;
      logic [RT_W-1:0]      d;
      logic [14:0]          h;
      logic                 sat;
   } item_type;

   typedef struct packed {
      logic [RT_W-1:0]      d;
      logic [14:0]          h;
      logic signed [15:0]   top;
      logic signed [15:0]   bot;
      logic signed [15:0]   ctr;
      logic signed [15:0]   lft;
      logic signed [15:0]   rgt;
      logic                 sat;
   } res_type;

   function automatic logic [15:0] clip16(input logic signed [17:0] v);
      logic [15:0] r;
      if (v > 18'sd32767) r = 16'h7FFF;
      else if (v < -18'sd32768) r = 16'h8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic clipped16(input logic signed [17:0] v);
      return (v > 18'sd32767) || (v < -18'sd32768);
   endfunction

endpackage

/* src/ssp_sqrt.sv */
module ssp_sqrt import ssp_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   radicand,
   output logic [RT_W-1:0]   root
);

   localparam int TW = SQ_W + 2;

   logic [SQ_W-1:0] rem_s  [0:SQRT_LAT-1];
   logic [RT_W-1:0] root_s [0:SQRT_LAT-1];
   logic [SQ_W-1:0] rem_ff  [0:SQRT_LAT-1];
   logic [RT_W-1:0] root_ff [0:SQRT_LAT-1];

   assign rem_s[0]  = radicand;
   assign root_s[0] = '0;

   genvar k;
   generate
      for (k = 0; k < SQRT_LAT; k++) begin : g_stage
         localparam int I = SQRT_LAT - 1 - k;
         logic [TW-1:0]   test;
         logic            ge;
         logic [SQ_W-1:0] rem_in;
         logic [RT_W-1:0] root_in;

         if (k > 0) begin : g_link
            assign rem_s[k]  = rem_ff[k-1];
            assign root_s[k] = root_ff[k-1];
         end

         assign test    = (TW'(root_s[k]) << (I + 1)) | (TW'(1) << (2 * I));
         assign ge      = TW'(rem_s[k]) >= test;
         assign rem_in  = ge ? rem_s[k] - test[SQ_W-1:0] : rem_s[k];
         assign root_in = ge ? root_s[k] | (RT_W'(1) << I) : root_s[k];

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
            end
         end
      end
   endgenerate

   assign root = root_ff[SQRT_LAT-1];

endmodule

/* src/ssp_div.sv */
module ssp_div import ssp_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [DIV_NW-1:0] num,
   input  logic signed [DIV_DW-1:0] den,
   output logic signed [15:0]       quot,
   output logic                     sat
);

   localparam int NST = DIV_QW + 2;
   localparam int CW  = DIV_DW + DIV_QW;

   typedef struct packed {
      logic [DIV_NW-1:0] rem;
      logic [DIV_DW-1:0] dmag;
      logic [DIV_QW-1:0] q;
      logic              neg;
      logic              nneg;
      logic              zero;
      logic              ovf;
   } stage_type;

   stage_type st_in [0:NST-1];
   stage_type st_ff [0:NST-1];
   logic signed [15:0] quot_in, quot_ff;
   logic               sat_in, sat_ff;
   stage_type          last;

   always_comb begin
      st_in[0].rem  = num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
      st_in[0].dmag = den[DIV_DW-1] ? DIV_DW'(-den) : DIV_DW'(den);
      st_in[0].q    = '0;
      st_in[0].neg  = num[DIV_NW-1] ^ den[DIV_DW-1];
      st_in[0].nneg = num[DIV_NW-1];
      st_in[0].zero = (den == '0);
      st_in[0].ovf  = 1'b0;
   end

   always_comb begin
      st_in[1]     = st_ff[0];
      st_in[1].ovf = CW'(st_ff[0].rem) >= {st_ff[0].dmag, {DIV_QW{1'b0}}};
   end

   genvar k;
   generate
      for (k = 0; k < DIV_QW; k++) begin : g_bit
         localparam int I = DIV_QW - 1 - k;
         logic [CW-1:0] test;
         logic          ge;
         assign test = CW'(st_ff[k+1].dmag) << I;
         assign ge   = CW'(st_ff[k+1].rem) >= test;
         always_comb begin
            st_in[k+2] = st_ff[k+1];
            if (ge) begin
               st_in[k+2].rem  = st_ff[k+1].rem - test[DIV_NW-1:0];
               st_in[k+2].q[I] = 1'b1;
            end
         end
      end
   endgenerate

   assign last = st_ff[NST-1];

   always_comb begin
      quot_in = last.q;
      sat_in  = 1'b0;
      if (last.zero) begin
         quot_in = last.nneg ? 16'sh8000 : 16'sh7FFF;
         sat_in  = 1'b1;
      end else if (last.ovf) begin
         quot_in = last.neg ? 16'sh8000 : 16'sh7FFF;
         sat_in  = 1'b1;
      end else if (last.neg) begin
         if (last.q > 16'd32768) begin
            quot_in = 16'sh8000;
            sat_in  = 1'b1;
         end else begin
            quot_in = -last.q;
         end
      end else if (last.q > 16'd32767) begin
         quot_in = 16'sh7FFF;
         sat_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NST; i++) begin
            st_ff[i] <= st_in[i];
         end
         quot_ff <= quot_in;
         sat_ff  <= sat_in;
      end
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;

endmodule

/* src/sprite_screen_projection_core.sv */
// Sprite screen projection: one sprite word per clock in while req_tready is
// high, one result word per visible sprite out, in order. A word with req_tuser
// (visible) low is taken and gives no result. Stages: three input and product
// stages, a 17-stage bit-per-cycle square root, a 19-stage bit-per-cycle divider
// for the size, two numerator stages, three parallel 19-stage dividers for the
// rows and the column, a column stage and the output register. Sustained rate is
// one word per cycle while rsp_tready is high; a two-entry output register and
// skid stage decouple the result side from the input.
`include "assert_macros.svh"

module sprite_screen_projection_core import ssp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // sprite_x, sprite_y, player_x, player_y, dir_x, dir_y, plane_x, plane_y, shrink
   input  logic [143:0]  req_tdata,
   // visible
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // distance, size_px, top_row, bottom_row, center_col, left_col, right_col,
   // saturated, zero fill
   output logic [119:0]  rsp_tdata
);

   logic en;

   logic               a_valid_ff;
   logic signed [16:0] a_rx_ff, a_ry_ff;
   logic signed [15:0] a_dx_ff, a_dy_ff, a_px_ff, a_py_ff, a_s_ff;

   logic               b_valid_ff;
   logic signed [15:0] b_s_ff;
   logic signed [33:0] b_rxx_ff, b_ryy_ff;
   logic signed [32:0] b_dyrx_ff, b_dxry_ff, b_pxry_ff, b_pyrx_ff;

   item_type           c_item_ff, c_item_in;
   logic [SQ_W-1:0]    c_sq_ff;

   item_type           sq_dly_ff [0:SQRT_LAT-1];
   item_type           hd_dly_ff [0:DIV_LAT-1];
   item_type           rd_dly_ff [0:DIV_LAT-1];
   item_type           hd_head_in;
   logic [RT_W-1:0]    root;
   logic signed [15:0] h_q;
   logic               h_sat;

   item_type           m_item_ff, m_item_in;
   logic signed [34:0] m_pt_ff, m_pb_ff;
   logic signed [43:0] m_cnum_ff;

   item_type           n_item_ff;
   logic signed [35:0] n_nt_ff, n_nb_ff;
   logic signed [43:0] n_cnum_ff;

   logic signed [15:0] top_q, bot_q, ctr_q;
   logic               top_sat, bot_sat, ctr_sat;

   logic               p_valid_ff;
   res_type            p_ff, p_in;
   logic               out_valid_ff, skid_valid_ff;
   res_type            out_ff, skid_ff;
   logic               take;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid && req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_rx_ff <= $signed({1'b0, req_tdata[15:0]}) - $signed({1'b0, req_tdata[47:32]});
         a_ry_ff <= $signed({1'b0, req_tdata[31:16]}) - $signed({1'b0, req_tdata[63:48]});
         a_dx_ff <= req_tdata[79:64];
         a_dy_ff <= req_tdata[95:80];
         a_px_ff <= req_tdata[111:96];
         a_py_ff <= req_tdata[127:112];
         a_s_ff  <= req_tdata[143:128];
      end
   end

   // products
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_s_ff    <= a_s_ff;
         b_rxx_ff  <= a_rx_ff * a_rx_ff;
         b_ryy_ff  <= a_ry_ff * a_ry_ff;
         b_dyrx_ff <= a_dy_ff * a_rx_ff;
         b_dxry_ff <= a_dx_ff * a_ry_ff;
         b_pxry_ff <= a_px_ff * a_ry_ff;
         b_pyrx_ff <= a_py_ff * a_rx_ff;
      end
   end

   // sums
   always_comb begin
      c_item_in       = '0;
      c_item_in.valid = b_valid_ff;
      c_item_in.s     = b_s_ff;
      c_item_in.tx    = 34'(b_dyrx_ff) - 34'(b_dxry_ff);
      c_item_in.ty    = 34'(b_pxry_ff) - 34'(b_pyrx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_item_ff <= '0;
      end else if (en) begin
         c_item_ff <= c_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_sq_ff <= SQ_W'(b_rxx_ff) + SQ_W'(b_ryy_ff);
      end
   end

   ssp_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (c_sq_ff),
      .root     (root)
   );

   ssp_div u_hdiv (
      .clock (clock),
      .en    (en),
      .num   (DIV_NW'(SCREEN_SIZE * 256)),
      .den   ($signed(DIV_DW'(root))),
      .quot  (h_q),
      .sat   (h_sat)
   );

   // side data alongside the square root and the size divider
   always_comb begin
      hd_head_in   = sq_dly_ff[SQRT_LAT-1];
      hd_head_in.d = root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_LAT; i++) sq_dly_ff[i].valid <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++)  hd_dly_ff[i].valid <= 1'b0;
      end else if (en) begin
         sq_dly_ff[0] <= c_item_ff;
         for (int i = 1; i < SQRT_LAT; i++) sq_dly_ff[i] <= sq_dly_ff[i-1];
         hd_dly_ff[0] <= hd_head_in;
         for (int i = 1; i < DIV_LAT; i++) hd_dly_ff[i] <= hd_dly_ff[i-1];
      end
   end

   // row products and column numerator
   logic [13:0]        m_half;
   logic signed [16:0] m_kt, m_kb;
   assign m_half = h_q[14:1];
   assign m_kt   = $signed(17'(SCREEN_CENTER)) - $signed({3'b0, m_half});
   assign m_kb   = $signed(17'(SCREEN_CENTER)) + $signed({3'b0, m_half});

   always_comb begin
      m_item_in     = hd_dly_ff[DIV_LAT-1];
      m_item_in.h   = h_q[14:0];
      m_item_in.sat = h_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_item_ff <= '0;
      end else if (en) begin
         m_item_ff <= m_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_pt_ff   <= m_kt * $signed({1'b0, hd_dly_ff[DIV_LAT-1].d});
         m_pb_ff   <= m_kb * $signed({1'b0, hd_dly_ff[DIV_LAT-1].d});
         m_cnum_ff <= ($signed(hd_dly_ff[DIV_LAT-1].tx) + $signed(hd_dly_ff[DIV_LAT-1].ty))
                      * $signed(44'(SCREEN_CENTER));
      end
   end

   // row numerators
   logic signed [35:0] n_cs;
   assign n_cs = $signed(m_item_ff.s) * $signed(36'(SCREEN_CENTER));

   always_ff @(posedge clock) begin
      if (reset) begin
         n_item_ff <= '0;
      end else if (en) begin
         n_item_ff <= m_item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_nt_ff   <= $signed({m_pt_ff[34], m_pt_ff}) - n_cs;
         n_nb_ff   <= $signed({m_pb_ff[34], m_pb_ff}) - n_cs;
         n_cnum_ff <= m_cnum_ff;
      end
   end

   ssp_div u_tdiv (
      .clock (clock),
      .en    (en),
      .num   ($signed({{(DIV_NW-36){n_nt_ff[35]}}, n_nt_ff})),
      .den   ($signed(DIV_DW'(n_item_ff.d))),
      .quot  (top_q),
      .sat   (top_sat)
   );

   ssp_div u_bdiv (
      .clock (clock),
      .en    (en),
      .num   ($signed({{(DIV_NW-36){n_nb_ff[35]}}, n_nb_ff})),
      .den   ($signed(DIV_DW'(n_item_ff.d))),
      .quot  (bot_q),
      .sat   (bot_sat)
   );

   ssp_div u_cdiv (
      .clock (clock),
      .en    (en),
      .num   (n_cnum_ff),
      .den   (n_item_ff.ty),
      .quot  (ctr_q),
      .sat   (ctr_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) rd_dly_ff[i].valid <= 1'b0;
      end else if (en) begin
         rd_dly_ff[0] <= n_item_ff;
         for (int i = 1; i < DIV_LAT; i++) rd_dly_ff[i] <= rd_dly_ff[i-1];
      end
   end

   // columns
   item_type           r_item;
   logic signed [17:0] lft_raw, rgt_raw;
   logic [15:0]        lft_c;
   assign r_item  = rd_dly_ff[DIV_LAT-1];
   assign lft_raw = $signed({{2{ctr_q[15]}}, ctr_q}) - $signed({4'b0, r_item.h[14:1]});
   assign lft_c   = clip16(lft_raw);
   assign rgt_raw = $signed({{2{lft_c[15]}}, lft_c}) + $signed({3'b0, r_item.h});

   always_comb begin
      p_in.d   = r_item.d;
      p_in.h   = r_item.h;
      p_in.top = top_q;
      p_in.bot = bot_q;
      p_in.ctr = ctr_q;
      p_in.lft = lft_c;
      p_in.rgt = clip16(rgt_raw);
      p_in.sat = r_item.sat || top_sat || bot_sat || ctr_sat
                 || clipped16(lft_raw) || clipped16(rgt_raw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= r_item.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   // output register and skid stage
   assign take = p_valid_ff && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= take;
         end
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_ff <= skid_valid_ff ? skid_ff : p_ff;
      end else if (take) begin
         skid_ff <= p_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff.sat, out_ff.rgt, out_ff.lft, out_ff.ctr,
                        out_ff.bot, out_ff.top, out_ff.h, out_ff.d};

   `SSP_ASSERT_NOW(skid_needs_out, clock, reset, !skid_valid_ff || out_valid_ff)
   `SSP_ASSERT_NOW(zero_dist_flags, clock, reset, !(out_valid_ff && out_ff.d == '0) || out_ff.sat)
   `SSP_ASSERT_NEXT(skid_loads, clock, reset, out_valid_ff && !rsp_tready && take, skid_valid_ff)

endmodule

/* dv/sprite_screen_projection_core_tb.sv */
module sprite_screen_projection_core_tb;
   import ssp_pkg::*;

   typedef struct {
      logic [16:0] distance;
      logic [14:0] size_px;
      logic [15:0] top_row;
      logic [15:0] bottom_row;
      logic [15:0] center_col;
      logic [15:0] left_col;
      logic [15:0] right_col;
      logic        saturated;
   } projection_type;

   localparam longint LIMIT_CYCLES = 400000;
   localparam int LATENCY = 62;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [143:0]  req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [119:0]  rsp_tdata;

   projection_type expected_projections[$];
   int            error_count = 0;
   longint        cycle_count = 0;
   bit            sender_idle = 1'b1;
   bit            receiver_idle = 1'b1;
   int            hold_off_cycles = 0;

   sprite_screen_projection_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic longint clip_word(longint v, ref bit flag);
      if (v > 32767) begin
         flag = 1;
         return 32767;
      end
      if (v < -32768) begin
         flag = 1;
         return -32768;
      end
      return v;
   endfunction

   function automatic longint divide_clipped(longint num, longint den, ref bit flag);
      if (den == 0) begin
         flag = 1;
         return (num >= 0) ? 32767 : -32768;
      end
      return clip_word(num / den, flag);
   endfunction

   function automatic longint floor_root(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic projection_type project_sprite(logic [143:0] f);
      projection_type p;
      bit sat;
      longint rx, ry, dx, dy, px, py, s, d, h, half, top, bot, tx, ty, ctr, lft, rgt;
      sat = 0;
      rx = longint'(f[15:0]) - longint'(f[47:32]);
      ry = longint'(f[31:16]) - longint'(f[63:48]);
      dx = longint'($signed(f[79:64]));
      dy = longint'($signed(f[95:80]));
      px = longint'($signed(f[111:96]));
      py = longint'($signed(f[127:112]));
      s  = longint'($signed(f[143:128]));
      d = floor_root(rx * rx + ry * ry);
      if (d == 0) begin
         sat = 1;
         h = 32767;
      end else begin
         h = (longint'(SCREEN_SIZE) * 256) / d;
         if (h > 32767) begin
            sat = 1;
            h = 32767;
         end
      end
      half = h / 2;
      top = divide_clipped((SCREEN_CENTER - half) * d - SCREEN_CENTER * s, d, sat);
      bot = divide_clipped((SCREEN_CENTER + half) * d - SCREEN_CENTER * s, d, sat);
      tx = dy * rx - dx * ry;
      ty = px * ry - py * rx;
      ctr = divide_clipped(SCREEN_CENTER * (ty + tx), ty, sat);
      lft = clip_word(ctr - half, sat);
      rgt = clip_word(lft + h, sat);
      p.distance = d[16:0];
      p.size_px = h[14:0];
      p.top_row = top[15:0];
      p.bottom_row = bot[15:0];
      p.center_col = ctr[15:0];
      p.left_col = lft[15:0];
      p.right_col = rgt[15:0];
      p.saturated = sat;
      return p;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s expected %0h actual %0h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      projection_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_projections.size() == 0) begin
            $error("result word with no expectation: %h", rsp_tdata);
            error_count++;
         end else begin
            e = expected_projections.pop_front();
            check_field("distance", longint'(e.distance), longint'(rsp_tdata[16:0]));
            check_field("size_px", longint'(e.size_px), longint'(rsp_tdata[31:17]));
            check_field("top_row", longint'(e.top_row), longint'(rsp_tdata[47:32]));
            check_field("bottom_row", longint'(e.bottom_row), longint'(rsp_tdata[63:48]));
            check_field("center_col", longint'(e.center_col), longint'(rsp_tdata[79:64]));
            check_field("left_col", longint'(e.left_col), longint'(rsp_tdata[95:80]));
            check_field("right_col", longint'(e.right_col), longint'(rsp_tdata[111:96]));
            check_field("saturated", longint'(e.saturated), longint'(rsp_tdata[112]));
         end
      end
   end

   // randomize ready in bursts; honor a long hold-off when requested
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 11);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 16);
            rsp_tready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_sprite(bit visible, logic [143:0] fields);
      int gap;
      if (sender_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= fields;
      req_tuser <= visible;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (visible) expected_projections.push_back(project_sprite(fields));
   endtask

   task automatic release_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [143:0] pack_sprite(logic [15:0] sx, logic [15:0] sy,
         logic [15:0] plx, logic [15:0] ply, logic [15:0] dx, logic [15:0] dy,
         logic [15:0] px, logic [15:0] py, logic [15:0] s);
      return {s, py, px, dy, dx, ply, plx, sy, sx};
   endfunction

   function automatic logic [143:0] random_sprite();
      logic [143:0] f;
      logic [15:0] plx, ply;
      int spread;
      for (int i = 0; i < 9; i++) f[i*16 +: 16] = 16'($urandom);
      case ($urandom_range(0, 3))
         0: ;
         1, 2: begin
            spread = 1 << $urandom_range(4, 13);
            plx = f[47:32];
            ply = f[63:48];
            f[15:0] = 16'(plx + $urandom_range(0, 2 * spread) - spread);
            f[31:16] = 16'(ply + $urandom_range(0, 2 * spread) - spread);
            f[143:128] = 16'($signed(16'($urandom_range(0, 1024))) - 512);
         end
         default: begin
            f[15:0] = 16'(f[47:32] + $urandom_range(0, 4) - 2);
            f[31:16] = 16'(f[63:48] + $urandom_range(0, 4) - 2);
         end
      endcase
      return f;
   endfunction

   task automatic wait_drained();
      while (expected_projections.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_sprite(1, pack_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                 16'h4000, 16'h0000, 16'h0000, 16'h2A00, 16'h0000));
      send_sprite(1, pack_sprite(16'h0500, 16'h0300, 16'h0500, 16'h0300,
                                 16'h4000, 16'h0000, 16'h0000, 16'h2A00, 16'h8000));
      send_sprite(0, pack_sprite(16'h0800, 16'h0800, 16'h0200, 16'h0200,
                                 16'h4000, 16'h0000, 16'h0000, 16'h2A00, 16'h0000));
      send_sprite(1, pack_sprite(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                                 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
      send_sprite(1, pack_sprite(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                                 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
      send_sprite(1, pack_sprite(16'h0801, 16'h0800, 16'h0800, 16'h0800,
                                 16'h4000, 16'h0000, 16'h0000, 16'h2A00, 16'h0100));
      send_sprite(1, pack_sprite(16'h0800, 16'h0900, 16'h0800, 16'h0800,
                                 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'hFF00));
      send_sprite(1, pack_sprite(16'h0A00, 16'h0800, 16'h0800, 16'h0800,
                                 16'h4000, 16'h0000, 16'h0000, 16'h2A00, 16'h0000));
      send_sprite(1, pack_sprite(16'h0800, 16'h1000, 16'h0800, 16'h0800,
                                 16'h4000, 16'h0000, 16'h0000, 16'h2A00, 16'h7FFF));
      send_sprite(1, pack_sprite(16'h0800, 16'h0802, 16'h0800, 16'h0800,
                                 16'hC000, 16'h4000, 16'hD600, 16'h2A00, 16'h8000));
      send_sprite(1, pack_sprite(16'h0800, 16'h0800, 16'h0800, 16'h0800,
                                 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_sprite(1, pack_sprite(16'h1234, 16'h5678, 16'h0FFF, 16'h7FFF,
                                 16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC, 16'h00FF));
      release_sender();
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 300;
      repeat (150) send_sprite($urandom_range(0, 5) != 0, random_sprite());
      release_sender();
      wait_drained();
   endtask

   task automatic test_random(int count);
      repeat (count) send_sprite($urandom_range(0, 7) != 0, random_sprite());
      release_sender();
   endtask

   task automatic test_full_rate(int count);
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      repeat (count) send_sprite($urandom_range(0, 7) != 0, random_sprite());
      release_sender();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_backpressure();
      test_random(950);
      test_full_rate(250);
      wait_drained();
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_projections.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
